/* rtl/core/vqdcm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vqdcm_pkg: shared definitions for the virtqueue descriptor chain manager
// Result codes, descriptor flag bits, word layouts and the sequencer's
// microcode program.
// ---------------------------------------------------------------------------
package vqdcm_pkg;

	// Field widths of the input and result words.
	localparam int IDX_FIELD_W = 3;
	localparam int BLOCK_W     = 32;
	localparam int AVAIL_W     = 16;
	localparam int SECTOR_W    = 33;
	localparam int FREED_W     = 4;
	localparam int CODE_W      = 2;
	localparam int FLAGS_W     = 2;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 72;

	// Result codes.
	localparam logic [CODE_W-1:0] RC_OK      = 2'd0;
	localparam logic [CODE_W-1:0] RC_NO_FREE = 2'd1;
	localparam logic [CODE_W-1:0] RC_INVALID = 2'd2;
	localparam logic [CODE_W-1:0] RC_ALREADY = 2'd3;

	// Descriptor flag bits.
	localparam logic [FLAGS_W-1:0] FLAG_NEXT  = 2'b01;
	localparam logic [FLAGS_W-1:0] FLAG_WRITE = 2'b10;

	typedef logic [2:0] step_t;
	typedef logic [2:0] op_t;
	typedef logic [1:0] cond_t;

	// Program steps.
	localparam step_t ST_IDLE     = 3'd0;
	localparam step_t ST_PICK0    = 3'd1;
	localparam step_t ST_PICK1    = 3'd2;
	localparam step_t ST_PICK2    = 3'd3;
	localparam step_t ST_COMMIT   = 3'd4;
	localparam step_t ST_REL_CHK  = 3'd5;
	localparam step_t ST_REL_LINK = 3'd6;
	localparam step_t ST_NOFREE   = 3'd7;

	// Datapath operations.
	localparam op_t OP_IDLE   = 3'd0;
	localparam op_t OP_PICK0  = 3'd1;
	localparam op_t OP_PICK1  = 3'd2;
	localparam op_t OP_PICK2  = 3'd3;
	localparam op_t OP_COMMIT = 3'd4;
	localparam op_t OP_CHECK  = 3'd5;
	localparam op_t OP_LINK   = 3'd6;
	localparam op_t OP_NOFREE = 3'd7;

	// Jump conditions.
	localparam cond_t C_NEVER  = 2'd0;
	localparam cond_t C_ACT    = 2'd1;
	localparam cond_t C_NOPICK = 2'd2;
	localparam cond_t C_STOP   = 2'd3;

	// One control word: operation, jump condition, jump target, fall-through step.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt;
		step_t nxt;
	} uword_t;

	// Microcode program.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		unique case (step)
			ST_IDLE:     w = '{OP_IDLE,   C_ACT,    ST_REL_CHK, ST_PICK0};
			ST_PICK0:    w = '{OP_PICK0,  C_NOPICK, ST_NOFREE,  ST_PICK1};
			ST_PICK1:    w = '{OP_PICK1,  C_NOPICK, ST_NOFREE,  ST_PICK2};
			ST_PICK2:    w = '{OP_PICK2,  C_NOPICK, ST_NOFREE,  ST_COMMIT};
			ST_COMMIT:   w = '{OP_COMMIT, C_NEVER,  ST_IDLE,    ST_IDLE};
			ST_REL_CHK:  w = '{OP_CHECK,  C_STOP,   ST_IDLE,    ST_REL_LINK};
			ST_REL_LINK: w = '{OP_LINK,   C_STOP,   ST_IDLE,    ST_REL_CHK};
			ST_NOFREE:   w = '{OP_NOFREE, C_NEVER,  ST_IDLE,    ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/vqdcm_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vqdcm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module vqdcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/virtqueue_descriptor_chain_manager.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// virtqueue_descriptor_chain_manager: split-virtqueue descriptor allocator
// Builds three-descriptor block request chains from a free pool, posts the
// head to the avail ring and frees chains by walking their next links.
// ---------------------------------------------------------------------------
// A small microcoded sequencer handles one word at a time. A submit steps
// through an accept step, one search step per descriptor (three) and a commit
// step; a submit that finds fewer than three free descriptors answers no_free
// and leaves the free map and the avail index unchanged.
// A release takes an accept step and then, per descriptor freed, a check step
// and a link step, since each link is read from the registered descriptor RAM;
// a walk that ends on a bad or free index ends with one more check step. A
// finished result waits in an output register, so the next word is accepted
// while it is still pending; the sequencer only stalls when a second result
// is ready before the first has been taken. The avail ring itself is not
// kept here: the block reports the ring slot and the new avail index.
// ---------------------------------------------------------------------------
module virtqueue_descriptor_chain_manager
	import vqdcm_pkg::*;
#(
	parameter int QUEUE_DEPTH       = 8,
	parameter int SECTORS_PER_BLOCK = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input words.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// write_op[0], block_number[32:1], head_index[35:33], zero fill[39:36]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action[0]
	input  logic                  s_tuser,
	// Result words.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// result_code[1:0], first_index[4:2], second_index[7:5], third_index[10:8],
	// ring_slot[13:11], avail_count[29:14], sector[62:30], data_flags[64:63],
	// freed_count[68:65], zero fill[71:69]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CUR_W  = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
	localparam int FC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W  = (FC_W > FREED_W) ? FC_W : FREED_W;
	localparam int LINK_W = IDX_W + FLAGS_W;
	localparam int PROD_W = BLOCK_W + 5;

	// Sequencer state.
	logic [2:0]             step_q;
	uword_t                 uw;

	// Datapath registers.
	logic                   write_op_q;
	logic [BLOCK_W-1:0]     block_q;
	logic [QUEUE_DEPTH-1:0] free_q;
	logic [QUEUE_DEPTH-1:0] scratch_q;
	logic [IDX_W-1:0]       pick0_q;
	logic [IDX_W-1:0]       pick1_q;
	logic [IDX_W-1:0]       pick2_q;
	logic [CUR_W-1:0]       cur_q;
	logic [CNT_W-1:0]       freed_q;
	logic [AVAIL_W-1:0]     avail_q;
	logic [IDX_W-1:0]       slot_q;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	// Combinational datapath signals.
	logic [QUEUE_DEPTH-1:0] low_onehot;
	logic [IDX_W-1:0]       low_idx;
	logic                   any_free;
	logic                   cur_bad;
	logic [IDX_W-1:0]       cur_idx;
	logic                   cur_free;
	logic [LINK_W-1:0]      rdata;
	logic [IDX_W-1:0]       rd_link;
	logic [FLAGS_W-1:0]     rd_flags;
	logic                   cond_true;
	logic                   post_req;
	logic                   hold;
	logic                   fire;
	logic                   post_en;
	logic [FLAGS_W-1:0]     dflags;
	logic [PROD_W-1:0]      prod;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [LINK_W-1:0]      ram_wdata;

	// Result fields.
	logic [CODE_W-1:0]      res_code;
	logic [IDX_FIELD_W-1:0] res_first;
	logic [IDX_FIELD_W-1:0] res_second;
	logic [IDX_FIELD_W-1:0] res_third;
	logic [IDX_FIELD_W-1:0] res_slot;
	logic [AVAIL_W-1:0]     res_avail;
	logic [SECTOR_W-1:0]    res_sector;
	logic [FLAGS_W-1:0]     res_flags;
	logic [FREED_W-1:0]     res_freed;

	assign uw = ucode(step_q);

	// Lowest free descriptor left in the search copy of the free map.
	assign low_onehot = scratch_q & (~scratch_q + QUEUE_DEPTH'(1));
	assign any_free   = |scratch_q;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (low_onehot[i]) begin
				low_idx = low_idx | IDX_W'(i);
			end
		end
	end

	// Current chain position of a release walk.
	assign cur_bad  = {1'b0, cur_q} >= (CUR_W + 1)'(QUEUE_DEPTH);
	assign cur_idx  = cur_q[IDX_W-1:0];
	assign cur_free = !cur_bad && free_q[cur_idx];
	assign rd_link  = rdata[LINK_W-1:FLAGS_W];
	assign rd_flags = rdata[FLAGS_W-1:0];

	// Jump condition selected by the control word.
	always_comb begin
		unique case (uw.cond)
			C_NEVER:  cond_true = 1'b0;
			C_ACT:    cond_true = s_tuser;
			C_NOPICK: cond_true = !any_free;
			C_STOP: begin
				if (uw.op == OP_CHECK) begin
					cond_true = cur_bad || cur_free;
				end else begin
					cond_true = (rd_flags & FLAG_NEXT) == '0;
				end
			end
		endcase
	end

	// Steps that hand a result to the output register.
	always_comb begin
		unique case (uw.op)
			OP_COMMIT, OP_NOFREE: post_req = 1'b1;
			OP_CHECK, OP_LINK:    post_req = cond_true;
			default:              post_req = 1'b0;
		endcase
	end

	assign hold     = ((uw.op == OP_IDLE) && !s_tvalid) ||
	                  (post_req && out_valid_q && !m_tready);
	assign fire     = !hold;
	assign post_en  = fire && post_req;
	assign s_tready = (uw.op == OP_IDLE);

	// Step counter with conditional jump.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (fire) begin
			step_q <= cond_true ? uw.tgt : uw.nxt;
		end
	end

	assign dflags = write_op_q ? FLAG_NEXT : (FLAG_NEXT | FLAG_WRITE);
	assign prod   = PROD_W'(block_q) * PROD_W'(SECTORS_PER_BLOCK);

	// Descriptor link writes: each pick links the previous one to itself, and the commit ends the chain at the third.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pick2_q;
		ram_wdata = {{IDX_W{1'b0}}, FLAG_WRITE};
		unique case (uw.op)
			OP_PICK1: begin
				ram_we    = fire && any_free;
				ram_waddr = pick0_q;
				ram_wdata = {low_idx, FLAG_NEXT};
			end
			OP_PICK2: begin
				ram_we    = fire && any_free;
				ram_waddr = pick1_q;
				ram_wdata = {low_idx, dflags};
			end
			OP_COMMIT: begin
				ram_we    = fire;
			end
			default: begin
				ram_we    = 1'b0;
			end
		endcase
	end

	vqdcm_ram #(
		.WIDTH (LINK_W),
		.DEPTH (QUEUE_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cur_idx),
		.rdata (rdata)
	);

	// Latched request and scratch registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (uw.op)
				OP_IDLE: begin
					write_op_q <= s_tdata[0];
					block_q    <= s_tdata[BLOCK_W:1];
					scratch_q  <= free_q;
				end
				OP_PICK0: begin
					pick0_q   <= low_idx;
					scratch_q <= scratch_q & ~low_onehot;
				end
				OP_PICK1: begin
					pick1_q   <= low_idx;
					scratch_q <= scratch_q & ~low_onehot;
				end
				OP_PICK2: begin
					pick2_q   <= low_idx;
					scratch_q <= scratch_q & ~low_onehot;
				end
				default: begin
				end
			endcase
		end
	end

	// Walk position and free count of a release.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (uw.op == OP_IDLE) begin
				cur_q   <= CUR_W'(s_tdata[BLOCK_W+IDX_FIELD_W:BLOCK_W+1]);
				freed_q <= '0;
			end else if (uw.op == OP_CHECK && !cond_true) begin
				freed_q <= freed_q + CNT_W'(1);
			end else if (uw.op == OP_LINK && !cond_true) begin
				cur_q   <= CUR_W'(rd_link);
			end
		end
	end

	// Free map, avail index and ring slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '1;
			avail_q <= '0;
			slot_q  <= '0;
		end else if (fire) begin
			if (uw.op == OP_COMMIT) begin
				free_q  <= scratch_q;
				avail_q <= avail_q + AVAIL_W'(1);
				// The slot follows avail_index mod depth, also across the 16-bit wrap.
				if (avail_q == '1 || slot_q == IDX_W'(QUEUE_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + IDX_W'(1);
				end
			end else if (uw.op == OP_CHECK && !cond_true) begin
				free_q[cur_idx] <= 1'b1;
			end
		end
	end

	// Result fields for the step that posts.
	always_comb begin
		res_code   = RC_OK;
		res_first  = '0;
		res_second = '0;
		res_third  = '0;
		res_slot   = '0;
		res_avail  = avail_q;
		res_sector = '0;
		res_flags  = '0;
		res_freed  = freed_q[FREED_W-1:0];
		unique case (uw.op)
			OP_COMMIT: begin
				res_first  = IDX_FIELD_W'(pick0_q);
				res_second = IDX_FIELD_W'(pick1_q);
				res_third  = IDX_FIELD_W'(pick2_q);
				res_slot   = IDX_FIELD_W'(slot_q);
				res_avail  = avail_q + AVAIL_W'(1);
				res_sector = prod[SECTOR_W-1:0];
				res_flags  = dflags;
				res_freed  = '0;
			end
			OP_NOFREE: begin
				res_code  = RC_NO_FREE;
				res_freed = '0;
			end
			OP_CHECK: begin
				res_code = cur_bad ? RC_INVALID : RC_ALREADY;
			end
			default: begin
				res_code = RC_OK;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_en) begin
			out_data_q <= {3'b000, res_freed, res_flags, res_sector, res_avail,
			               res_slot, res_third, res_second, res_first, res_code};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A commit removes exactly three descriptors from the pool.
	a_commit_takes_three: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && uw.op == OP_COMMIT) |=>
		($countones(free_q) + 3 == $countones($past(free_q))))
		else $error("commit did not take exactly three descriptors");

	// The avail index moves only on a commit.
	a_avail_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && uw.op == OP_COMMIT) |=> $stable(avail_q))
		else $error("avail index changed outside a commit");

	// The three picked descriptors are distinct and in ascending order.
	a_picks_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_COMMIT) |-> (pick0_q < pick1_q && pick1_q < pick2_q))
		else $error("picked descriptors are not distinct and ascending");

	// While a link is read, the descriptor it came from has just been freed.
	a_link_from_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_LINK) |-> (!cur_bad && free_q[cur_idx]))
		else $error("link read from a descriptor that was not freed");

endmodule
